// ===== hdl/tcd_pkg.sv =====
// Package for the tick cadence divider: widths, register indexes, reset values
// and the packed word types of the item and result channels.
// No dependencies; used by tick_cadence_divider_unit.
package tcd_pkg;

	localparam int NUM_CHANNELS = 3;
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int MODE_W       = 2;
	localparam int TICK_W       = 16;
	localparam int PERIOD_W     = 8;
	localparam int ACC_W        = TICK_W + 1;
	localparam int DROP_W       = 32;
	localparam int STEP_CNT_W   = $clog2(ACC_W + 1);
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SESSION = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd4;
	localparam logic [PERIOD_W-1:0] STEP_RESET   = 8'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TICK_W-1:0] tick_count;
	} item_t;

	typedef struct packed {
		logic              due;
		logic [TICK_W-1:0] credited_ticks;
		logic [DROP_W-1:0] dropped_total;
	} result_t;

endpackage

// ===== hdl/tick_cadence_divider_unit.sv =====
// Tick cadence divider: per-channel pending-tick accumulators and saturating
// dropped-period counters, with a shared bit-serial restoring divider.
// Depends on tcd_pkg.
//
// Usage: an item word (channel in mode, tick_count) enters on item_valid and
// item_ready; one result word leaves on result_valid and result_ready. The
// configuration channel (cfg_index, cfg_data) is always ready and should only
// be written while no item is in flight.
// An item that needs no division (pass-through, still pending, or an unknown
// channel) goes from idle straight to the write-back step, which raises
// result_valid. An item whose accumulated ticks reach a full period first runs
// the divider, one quotient bit per cycle through a single 9-bit subtractor,
// and then raises result_valid from the write-back step.
// The sequencer takes no new item until it is done with the last one;
// item_ready is high only while the sequencer is idle.
// Reset clears all pending and dropped counts and loads period 4, step 4 and an
// inactive session. The result register holds one finished word; if the
// receiver stalls, the next item is still accepted and computed, and waits in
// its final step until the result register is free.
module tick_cadence_divider_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  tcd_pkg::item_t                         item,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output tcd_pkg::result_t                       result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tcd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [tcd_pkg::PERIOD_W-1:0]           cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_WB} state_t;
	typedef enum logic [1:0] {K_ZERO, K_PASS, K_HOLD, K_DIV} kind_t;

	state_t                           state_q;
	kind_t                            kind_q;
	kind_t                            kind_in;
	logic [tcd_pkg::PERIOD_W-1:0]     period_q;
	logic [tcd_pkg::PERIOD_W-1:0]     step_q;
	logic                             session_q;
	logic [tcd_pkg::PERIOD_W-1:0]     pending_q [tcd_pkg::NUM_CHANNELS];
	logic [tcd_pkg::DROP_W-1:0]       dropped_q [tcd_pkg::NUM_CHANNELS];
	logic [tcd_pkg::CH_W-1:0]         ch_q;
	logic [tcd_pkg::TICK_W-1:0]       elapsed_q;
	logic [tcd_pkg::ACC_W-1:0]        dvd_q;
	logic [tcd_pkg::PERIOD_W-1:0]     rem_q;
	logic [tcd_pkg::STEP_CNT_W-1:0]   cnt_q;
	logic                             result_valid_q;
	tcd_pkg::result_t                 result_q;

	logic                             ch_ok;
	logic                             high_rate;
	logic [tcd_pkg::CH_W-1:0]         ch_in;
	logic [tcd_pkg::PERIOD_W-1:0]     pend_rd;
	logic [tcd_pkg::ACC_W-1:0]        acc_in;
	logic [tcd_pkg::ACC_W-1:0]        period_ext;
	logic [tcd_pkg::PERIOD_W:0]       trial;
	logic                             trial_ge;
	logic [tcd_pkg::PERIOD_W:0]       trial_sub;
	logic [tcd_pkg::DROP_W-1:0]       drop_rd;
	logic [tcd_pkg::DROP_W:0]         drop_sum;
	logic [tcd_pkg::DROP_W-1:0]       drop_sat;
	logic                             wb_go;

	assign item_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		ch_ok      = int'(item.mode) < tcd_pkg::NUM_CHANNELS;
		high_rate  = session_q && (step_q < period_q);
		ch_in      = tcd_pkg::CH_W'(item.mode);
		pend_rd    = ch_ok ? pending_q[ch_in] : '0;
		acc_in     = tcd_pkg::ACC_W'(pend_rd) + tcd_pkg::ACC_W'(item.tick_count);
		period_ext = tcd_pkg::ACC_W'(period_q);
		priority if (!ch_ok) begin
			kind_in = K_ZERO;
		end else if (!high_rate) begin
			kind_in = K_PASS;
		end else if (acc_in < period_ext) begin
			kind_in = K_HOLD;
		end else begin
			kind_in = K_DIV;
		end
		trial     = {rem_q, dvd_q[tcd_pkg::ACC_W-1]};
		trial_ge  = trial >= {1'b0, period_q};
		trial_sub = trial - {1'b0, period_q};
		drop_rd   = dropped_q[ch_q];
		drop_sum  = {1'b0, drop_rd} + (tcd_pkg::DROP_W + 1)'(dvd_q);
		drop_sat  = drop_sum[tcd_pkg::DROP_W] ? '1 : drop_sum[tcd_pkg::DROP_W-1:0];
		wb_go     = !result_valid_q || result_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			kind_q         <= K_ZERO;
			period_q       <= tcd_pkg::PERIOD_RESET;
			step_q         <= tcd_pkg::STEP_RESET;
			session_q      <= 1'b0;
			ch_q           <= '0;
			elapsed_q      <= '0;
			dvd_q          <= '0;
			rem_q          <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			for (int i = 0; i < tcd_pkg::NUM_CHANNELS; i++) begin
				pending_q[i] <= '0;
				dropped_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					tcd_pkg::CFG_PERIOD:  period_q  <= cfg_data;
					tcd_pkg::CFG_STEP:    step_q    <= cfg_data;
					tcd_pkg::CFG_SESSION: session_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_WB && wb_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						kind_q    <= kind_in;
						ch_q      <= ch_in;
						elapsed_q <= item.tick_count;
						dvd_q     <= acc_in - period_ext;
						rem_q     <= (kind_in == K_DIV) ? '0
						                                : acc_in[tcd_pkg::PERIOD_W-1:0];
						cnt_q     <= '0;
						state_q   <= (kind_in == K_DIV) ? ST_DIV : ST_WB;
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? trial_sub[tcd_pkg::PERIOD_W-1:0]
					                  : trial[tcd_pkg::PERIOD_W-1:0];
					dvd_q <= {dvd_q[tcd_pkg::ACC_W-2:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tcd_pkg::STEP_CNT_W'(tcd_pkg::ACC_W - 1)) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_go) begin
						state_q        <= ST_IDLE;
						unique case (kind_q)
							K_ZERO: begin
								result_q <= '0;
							end
							K_PASS: begin
								pending_q[ch_q]         <= '0;
								result_q.due            <= 1'b1;
								result_q.credited_ticks <= elapsed_q;
								result_q.dropped_total  <= drop_rd;
							end
							K_HOLD: begin
								pending_q[ch_q]         <= rem_q;
								result_q.due            <= 1'b0;
								result_q.credited_ticks <= '0;
								result_q.dropped_total  <= drop_rd;
							end
							K_DIV: begin
								pending_q[ch_q]         <= rem_q;
								dropped_q[ch_q]         <= drop_sat;
								result_q.due            <= 1'b1;
								result_q.credited_ticks <= tcd_pkg::TICK_W'(period_q);
								result_q.dropped_total  <= drop_sat;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/tick_cadence_divider_unit_test.sv =====
// Self-checking testbench for tick_cadence_divider_unit: directed and random item words,
// predicted per channel and compared field by field with each result word.
// Depends on tcd_pkg and tick_cadence_divider_unit.
module tick_cadence_divider_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [tcd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int END_WAIT = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	tcd_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	tcd_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tcd_pkg::PERIOD_W-1:0] cfg_data = '0;

	logic [tcd_pkg::PERIOD_W-1:0] period_reg = tcd_pkg::PERIOD_RESET;
	logic [tcd_pkg::PERIOD_W-1:0] step_reg = tcd_pkg::STEP_RESET;
	logic session_reg = 1'b0;
	logic [tcd_pkg::PERIOD_W-1:0] pending_by_channel [tcd_pkg::NUM_CHANNELS];
	logic [tcd_pkg::DROP_W-1:0] dropped_by_channel [tcd_pkg::NUM_CHANNELS];

	tcd_pkg::result_t awaited_results [$];
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int error_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int register_writes = 0;
	int cycle_count = 0;

	tick_cadence_divider_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	function automatic tcd_pkg::result_t advance_channel(input tcd_pkg::item_t w);
		tcd_pkg::result_t r;
		logic [tcd_pkg::ACC_W-1:0] acc;
		logic [tcd_pkg::ACC_W-1:0] whole_periods;
		logic [tcd_pkg::DROP_W:0] sum;
		int ch;
		r = '0;
		ch = w.mode;
		if (ch >= tcd_pkg::NUM_CHANNELS)
			return r;
		if (!(session_reg && step_reg < period_reg) || period_reg == '0) begin
			pending_by_channel[ch] = '0;
			r.due = 1'b1;
			r.credited_ticks = w.tick_count;
		end else begin
			acc = tcd_pkg::ACC_W'(pending_by_channel[ch]) + tcd_pkg::ACC_W'(w.tick_count);
			if (acc >= tcd_pkg::ACC_W'(period_reg)) begin
				acc = acc - tcd_pkg::ACC_W'(period_reg);
				if (acc >= tcd_pkg::ACC_W'(period_reg)) begin
					whole_periods = acc / tcd_pkg::ACC_W'(period_reg);
					sum = {1'b0, dropped_by_channel[ch]}
						+ (tcd_pkg::DROP_W + 1)'(whole_periods);
					dropped_by_channel[ch] = sum[tcd_pkg::DROP_W] ? '1
						: sum[tcd_pkg::DROP_W-1:0];
					acc = acc % tcd_pkg::ACC_W'(period_reg);
				end
				r.due = 1'b1;
				r.credited_ticks = tcd_pkg::TICK_W'(period_reg);
			end
			pending_by_channel[ch] = acc[tcd_pkg::PERIOD_W-1:0];
		end
		r.dropped_total = dropped_by_channel[ch];
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [tcd_pkg::DROP_W-1:0] want,
			input logic [tcd_pkg::DROP_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		tcd_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h",
					$realtime, result);
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("due", tcd_pkg::DROP_W'(want.due),
					tcd_pkg::DROP_W'(result.due));
				compare_field("credited_ticks", tcd_pkg::DROP_W'(want.credited_ticks),
					tcd_pkg::DROP_W'(result.credited_ticks));
				compare_field("dropped_total", want.dropped_total, result.dropped_total);
				words_checked++;
			end
		end
	end

	task automatic write_register(input logic [tcd_pkg::CFG_IDX_W-1:0] idx,
			input logic [tcd_pkg::PERIOD_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tcd_pkg::CFG_PERIOD: period_reg = data;
			tcd_pkg::CFG_STEP: step_reg = data;
			tcd_pkg::CFG_SESSION: session_reg = data[0];
			default: ;
		endcase
		register_writes++;
		@(posedge clk);
	endtask

	task automatic configure(input logic [tcd_pkg::PERIOD_W-1:0] period,
			input logic [tcd_pkg::PERIOD_W-1:0] step,
			input logic [tcd_pkg::PERIOD_W-1:0] session);
		write_register(tcd_pkg::CFG_PERIOD, period);
		write_register(tcd_pkg::CFG_STEP, step);
		write_register(tcd_pkg::CFG_SESSION, session);
	endtask

	task automatic send_word(input logic [tcd_pkg::MODE_W-1:0] mode,
			input logic [tcd_pkg::TICK_W-1:0] ticks);
		tcd_pkg::item_t w;
		w.mode = mode;
		w.tick_count = ticks;
		item <= w;
		if (!item_valid)
			item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		awaited_results.push_back(advance_channel(w));
		words_sent++;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_word(2'd0, 16'h0000);
		send_word(2'd1, 16'hFFFF);
		send_word(2'd2, 16'h5555);
		send_word(2'd3, 16'hAAAA);
		wait_for_drain();
	endtask

	task automatic test_high_rate_accumulation();
		configure(8'd4, 8'd4, 8'd1);
		send_word(2'd0, 16'd3);
		wait_for_drain();
		write_register(tcd_pkg::CFG_STEP, 8'd1);
		send_word(2'd0, 16'd1);
		send_word(2'd0, 16'd2);
		send_word(2'd0, 16'd1);
		send_word(2'd0, 16'd13);
		send_word(2'd1, 16'hFFFF);
		send_word(2'd2, 16'd3);
		send_word(2'd3, 16'hFFFF);
		wait_for_drain();
		configure(8'd255, 8'd254, 8'd1);
		send_word(2'd0, 16'hFFFF);
		send_word(2'd2, 16'd254);
		wait_for_drain();
	endtask

	task automatic test_zero_period_and_spare_index();
		write_register(tcd_pkg::CFG_PERIOD, 8'd0);
		write_register(CFG_SPARE, 8'hA5);
		send_word(2'd2, 16'd1);
		send_word(2'd1, 16'h8000);
		wait_for_drain();
		configure(8'd1, 8'd0, 8'd1);
		send_word(2'd2, 16'hFFFF);
		send_word(2'd2, 16'd0);
		wait_for_drain();
		write_register(tcd_pkg::CFG_SESSION, 8'hFE);
		send_word(2'd2, 16'd7);
		send_word(2'd0, 16'h00FF);
		wait_for_drain();
	endtask

	task automatic run_random_phase(input logic [tcd_pkg::PERIOD_W-1:0] period,
			input logic [tcd_pkg::PERIOD_W-1:0] step,
			input logic [tcd_pkg::PERIOD_W-1:0] session,
			input int count, input int idle_pct, input int stall_pct);
		logic [tcd_pkg::MODE_W-1:0] mode;
		logic [tcd_pkg::TICK_W-1:0] ticks;
		int pick;
		int span;
		configure(period, step, session);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		span = 2 * int'(period) + 1;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_for_drain();
			mode = ($urandom_range(0, 99) < 6) ? 2'd3
				: tcd_pkg::MODE_W'($urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			if (pick < 60)
				ticks = tcd_pkg::TICK_W'($urandom_range(0, span));
			else if (pick < 80)
				ticks = tcd_pkg::TICK_W'($urandom_range(0, 600));
			else
				ticks = tcd_pkg::TICK_W'($urandom_range(0, 65535));
			send_word(mode, ticks);
		end
		wait_for_drain();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	task automatic test_random_traffic();
		logic [tcd_pkg::PERIOD_W-1:0] p;
		logic [tcd_pkg::PERIOD_W-1:0] s;
		run_random_phase(8'd4, 8'd1, 8'd1, 90, 0, 0);
		run_random_phase(8'd255, 8'd0, 8'd1, 90, 69, 0);
		run_random_phase(8'd1, 8'd0, 8'd1, 90, 0, 69);
		p = tcd_pkg::PERIOD_W'($urandom_range(2, 255));
		s = tcd_pkg::PERIOD_W'($urandom_range(0, p - 1));
		run_random_phase(p, s, 8'd1, 90, 10, 10);
		run_random_phase(8'd0, tcd_pkg::PERIOD_W'($urandom_range(0, 255)),
			tcd_pkg::PERIOD_W'(($urandom_range(0, 127) << 1) | 1), 40, 0, 0);
		run_random_phase(tcd_pkg::PERIOD_W'($urandom_range(1, 255)),
			tcd_pkg::PERIOD_W'($urandom_range(0, 255)),
			tcd_pkg::PERIOD_W'($urandom_range(0, 127) << 1), 40, 69, 0);
		p = tcd_pkg::PERIOD_W'($urandom_range(1, 255));
		run_random_phase(p, tcd_pkg::PERIOD_W'($urandom_range(p, 255)), 8'd1, 40, 0, 69);
		run_random_phase(8'd17, 8'd3, 8'd1, 90, 10, 10);
		for (int k = 0; k < 4; k++)
			run_random_phase(tcd_pkg::PERIOD_W'($urandom_range(0, 255)),
				tcd_pkg::PERIOD_W'($urandom_range(0, 255)),
				tcd_pkg::PERIOD_W'($urandom_range(0, 255)), 20, 25 * k, 69 - 20 * k);
	endtask

	initial begin
		for (int c = 0; c < tcd_pkg::NUM_CHANNELS; c++) begin
			pending_by_channel[c] = '0;
			dropped_by_channel[c] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_high_rate_accumulation();
		test_zero_period_and_spare_index();
		test_random_traffic();
		wait_for_drain();
		repeat (END_WAIT) @(posedge clk);
		$display("Covered %0d item words and %0d result words over %0d register writes,",
			words_sent, words_checked, register_writes);
		$display("with pass-through, high-rate, zero-period and unknown-channel traffic.");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/tcd_pkg.sv
hdl/tick_cadence_divider_unit.sv
tb/sv/tick_cadence_divider_unit_test.sv
